// ----- rtl/assc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// assc_pkg: shared types and constants for the array sort and statistics core
// Holds the request, response and statistics structs, the register indexes
// and the prime lookup used while a set is loaded.
// ----------------------------------------------------------------------------
package assc_pkg;

   localparam int unsigned VAL_W         = 8;
   localparam int unsigned TCNT_W        = 7;
   localparam int unsigned CSR_IDX_W     = 1;
   localparam int unsigned CSR_DATA_W    = 8;
   localparam int unsigned MAX_ELEMS_DEF = 64;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SORT_DESC    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_TARGET = 1'd1;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0]  sorted_value;
      logic              last_out;
      logic [TCNT_W-1:0] target_count;
      logic              was_ascending;
      logic [VAL_W-1:0]  min_odd;
      logic              min_odd_found;
      logic [VAL_W-1:0]  max_prime;
      logic              max_prime_found;
      logic              dropped;
   } rsp_type;

   typedef struct packed {
      logic [TCNT_W-1:0] target_count;
      logic              ascending;
      logic [VAL_W-1:0]  min_odd;
      logic              odd_seen;
      logic [VAL_W-1:0]  max_prime;
      logic              prime_seen;
      logic              overflow;
   } stats_type;

   // Constant table of the primes that fit in eight bits.
   function automatic logic is_prime8(input logic [VAL_W-1:0] v);
      logic p;
      unique case (v)
         8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29,
         8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67,
         8'd71, 8'd73, 8'd79, 8'd83, 8'd89, 8'd97, 8'd101, 8'd103, 8'd107,
         8'd109, 8'd113, 8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151,
         8'd157, 8'd163, 8'd167, 8'd173, 8'd179, 8'd181, 8'd191, 8'd193,
         8'd197, 8'd199, 8'd211, 8'd223, 8'd227, 8'd229, 8'd233, 8'd239,
         8'd241, 8'd251: p = 1'b1;
         default:        p = 1'b0;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/assc_stats.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// assc_stats: running set statistics
// Tracks target matches, input ordering, smallest odd and largest prime
// element as a set is loaded, and the overflow flag for discarded elements.
// ----------------------------------------------------------------------------
module assc_stats import assc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             upd,
   input  wire logic             drop,
   input  wire logic             clear,
   input  wire logic             has_prev,
   input  wire logic [VAL_W-1:0] value,
   input  wire logic [VAL_W-1:0] target,
   output stats_type             stats
);

   logic [TCNT_W-1:0] cnt_ff, cnt_in;
   logic              asc_ff, asc_in;
   logic [VAL_W-1:0]  prev_ff, prev_in;
   logic [VAL_W-1:0]  modd_ff, modd_in;
   logic              odd_ff, odd_in;
   logic [VAL_W-1:0]  mprm_ff, mprm_in;
   logic              prm_ff, prm_in;
   logic              ovf_ff, ovf_in;

   always_comb begin
      cnt_in  = cnt_ff;
      asc_in  = asc_ff;
      prev_in = prev_ff;
      modd_in = modd_ff;
      odd_in  = odd_ff;
      mprm_in = mprm_ff;
      prm_in  = prm_ff;
      ovf_in  = ovf_ff;
      priority if (clear) begin
         cnt_in  = '0;
         asc_in  = 1'b1;
         prev_in = '0;
         modd_in = '0;
         odd_in  = 1'b0;
         mprm_in = '0;
         prm_in  = 1'b0;
         ovf_in  = 1'b0;
      end else if (upd) begin
         if (has_prev && (prev_ff > value)) begin
            asc_in = 1'b0;
         end
         prev_in = value;
         if (value == target) begin
            cnt_in = cnt_ff + TCNT_W'(1);
         end
         if (value[0] && (!odd_ff || (value < modd_ff))) begin
            modd_in = value;
            odd_in  = 1'b1;
         end
         if (is_prime8(value) && (!prm_ff || (value > mprm_ff))) begin
            mprm_in = value;
            prm_in  = 1'b1;
         end
      end else if (drop) begin
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         asc_ff  <= 1'b1;
         prev_ff <= '0;
         modd_ff <= '0;
         odd_ff  <= 1'b0;
         mprm_ff <= '0;
         prm_ff  <= 1'b0;
         ovf_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         asc_ff  <= asc_in;
         prev_ff <= prev_in;
         modd_ff <= modd_in;
         odd_ff  <= odd_in;
         mprm_ff <= mprm_in;
         prm_ff  <= prm_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign stats.target_count = cnt_ff;
   assign stats.ascending    = asc_ff;
   assign stats.min_odd      = modd_ff;
   assign stats.odd_seen     = odd_ff;
   assign stats.max_prime    = mprm_ff;
   assign stats.prime_seen   = prm_ff;
   assign stats.overflow     = ovf_ff;

endmodule
`default_nettype wire

// ----- rtl/array_sort_and_statistics_core.sv -----
`default_nettype none
// Loading takes one cycle per request; requests that are not last give no response.
// On the last request the set of n elements is sorted by one shared compare unit
// working in place over the element memory.
// After a read, each response is registered and held while stalled; no request is taken.
// Reset clears the sequencer, the element count, the statistics and both registers;
// the element memory is left as it is and only entries of the current set are read.
// ----------------------------------------------------------------------------
// array_sort_and_statistics_core: exchange sort with set statistics
// Stores a set of 8-bit elements, sorts it in place with an exchange sort
// (one compare and at most one memory write per cycle) and emits it in order.
// ----------------------------------------------------------------------------
module array_sort_and_statistics_core import assc_pkg::*; #(
   parameter int unsigned MAX_ELEMS = MAX_ELEMS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned CNT_W  = $clog2(MAX_ELEMS + 1);
   localparam int unsigned ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_RDI   = 3'd1;
   localparam logic [2:0] S_GETI  = 3'd2;
   localparam logic [2:0] S_RUN   = 3'd3;
   localparam logic [2:0] S_WRI   = 3'd4;
   localparam logic [2:0] S_ERD   = 3'd5;
   localparam logic [2:0] S_EOUT  = 3'd6;
   localparam logic [2:0] S_EWAIT = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [VAL_W-1:0]  ai_ff, ai_in;
   logic              desc_ff, desc_in;
   logic [VAL_W-1:0]  target_ff, target_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [VAL_W-1:0]  mem [MAX_ELEMS];
   logic [VAL_W-1:0]  rdata_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;

   logic              full;
   logic [CNT_W-1:0]  cnt_m1;
   logic [ADDR_W-1:0] last_idx;
   logic              swap;
   logic              multi;
   logic              st_upd, st_drop, st_clear;
   stats_type         stats;

   assc_stats u_stats (
      .clock    (clock),
      .reset    (reset),
      .upd      (st_upd),
      .drop     (st_drop),
      .clear    (st_clear),
      .has_prev (count_ff != '0),
      .value    (req_data.value),
      .target   (target_ff),
      .stats    (stats)
   );

   assign full     = (count_ff == CNT_W'(MAX_ELEMS));
   assign cnt_m1   = count_ff - CNT_W'(1);
   assign last_idx = cnt_m1[ADDR_W-1:0];
   // The shared compare unit: does the held element belong after the one read?
   assign swap     = desc_ff ? (ai_ff < rdata_ff) : (ai_ff > rdata_ff);
   // More than one element stored once this request is taken.
   assign multi    = full ? (count_ff > CNT_W'(1)) : (count_ff != '0);

   always_comb begin
      desc_in   = desc_ff;
      target_in = target_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SORT_DESC:    desc_in   = csr_wdata[0];
            CSR_COUNT_TARGET: target_in = csr_wdata[VAL_W-1:0];
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      ai_in        = ai_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      st_upd       = 1'b0;
      st_drop      = 1'b0;
      st_clear     = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (full) begin
                  st_drop = 1'b1;
               end else begin
                  st_upd   = 1'b1;
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  wr_data  = req_data.value;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last) begin
                  i_in = '0;
                  k_in = '0;
                  state_in = multi ? S_RDI : S_ERD;
               end
            end
         end
         S_RDI: begin
            rd_addr  = i_ff;
            state_in = S_GETI;
         end
         S_GETI: begin
            ai_in    = rdata_ff;
            rd_addr  = ADDR_W'(i_ff + 1'b1);
            j_in     = ADDR_W'(i_ff + 1'b1);
            state_in = S_RUN;
         end
         S_RUN: begin
            if (swap) begin
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = ai_ff;
               ai_in   = rdata_ff;
            end
            if (j_ff == last_idx) begin
               state_in = S_WRI;
            end else begin
               rd_addr = ADDR_W'(j_ff + 1'b1);
               j_in    = ADDR_W'(j_ff + 1'b1);
            end
         end
         S_WRI: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff;
            wr_data  = ai_ff;
            i_in     = ADDR_W'(i_ff + 1'b1);
            state_in = (ADDR_W'(i_ff + 1'b1) == last_idx) ? S_ERD : S_RDI;
         end
         S_ERD: begin
            rd_addr  = k_ff;
            state_in = S_EOUT;
         end
         S_EOUT: begin
            rsp_in.sorted_value    = rdata_ff;
            rsp_in.last_out        = (k_ff == last_idx);
            rsp_in.target_count    = stats.target_count;
            rsp_in.was_ascending   = stats.ascending;
            rsp_in.min_odd         = stats.min_odd;
            rsp_in.min_odd_found   = stats.odd_seen;
            rsp_in.max_prime       = stats.max_prime;
            rsp_in.max_prime_found = stats.prime_seen;
            rsp_in.dropped         = stats.overflow;
            rsp_valid_in           = 1'b1;
            state_in               = S_EWAIT;
         end
         S_EWAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (k_ff == last_idx) begin
                  st_clear = 1'b1;
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  rd_addr  = ADDR_W'(k_ff + 1'b1);
                  k_in     = ADDR_W'(k_ff + 1'b1);
                  state_in = S_EOUT;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         desc_ff      <= 1'b0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         desc_ff      <= desc_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ai_ff  <= ai_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_EWAIT))
      else $error("response valid outside the emit wait state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMS))
      else $error("element count beyond capacity");

   a_inner_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> ((j_ff > i_ff) && (j_ff <= last_idx)))
      else $error("inner sort index out of range");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && rsp_ff.last_out) |=>
         ((count_ff == '0) && (state_ff == S_LOAD)))
      else $error("set not cleared after the final response");

endmodule
`default_nettype wire
